// ===== hdl/lsh_pkg.sv =====
// shared types, constants and step functions for the lod select hysteresis block
// no dependencies

package lsh_pkg;

    localparam int LOD_LEVELS_DEF = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int QDEPTH         = 4;
    localparam int SQ_W           = 52;
    localparam int ROOT_W         = 26;
    localparam int REM_W          = 29;
    localparam int SQ_STEPS       = SQ_W / 2;
    localparam int DEN_W          = 42;
    localparam int DIV_W          = 58;
    localparam int FRAC_W         = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS = 3'd6;

    typedef struct packed {
        logic signed [23:0] box_min_x;
        logic signed [23:0] box_min_y;
        logic signed [23:0] box_min_z;
        logic signed [23:0] box_max_x;
        logic signed [23:0] box_max_y;
        logic signed [23:0] box_max_z;
        logic [3:0]         level_count;
        logic [3:0]         prev_level;
    } t_in_word;

    typedef struct packed {
        logic [3:0] level;
        logic       cache_write;
    } t_out_word;

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic [15:0]        tan_half_fov;
        logic signed [4:0]  forced_level;
        logic [15:0]        hysteresis;
        logic [47:0]        level_thresholds;
    } t_cfg;

    typedef struct packed {
        logic       use_calc;
        logic [3:0] lvl_fixed;
        logic       wr_fixed;
        logic [3:0] count;
        logic [3:0] prev;
    } t_meta;

    typedef struct packed {
        t_meta       meta;
        logic [23:0] dx;
        logic [23:0] dy;
        logic [23:0] dz;
        logic [25:0] ex;
        logic [25:0] ey;
        logic [25:0] ez;
    } t_qword;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dsh;
        logic [FRAC_W-1:0] q;
    } t_div;

    // one result bit of the integer square root
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        t_sqrt            o;
        cur   = {s.rem[REM_W-3:0], s.rad[SQ_W-1:SQ_W-2]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[SQ_W-3:0], 2'b00};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic t_div div_step(input t_div s);
        logic ge;
        t_div o;
        ge    = (s.rem >= s.dsh);
        o.rem = ge ? (s.rem - s.dsh) : s.rem;
        o.dsh = s.dsh >> 1;
        o.q   = {s.q[FRAC_W-2:0], ge};
        return o;
    endfunction

endpackage

// ===== hdl/lod_select_hysteresis_core.sv =====
// top level of the lod select hysteresis block
// depends on lsh_pkg, lsh_front, lsh_queue, lsh_back
// throughput: one word per cycle while the output is not stalled, input and output both at full rate
// path from input accept to result valid: the queue, then the registered stages
// (squares, sums, 26 square root steps, denominator, 16 quotient bits, output register)
// reset: synchronous, clears pipeline valids and queue, loads register defaults

module lod_select_hysteresis_core #(
    parameter int LOD_LEVELS = lsh_pkg::LOD_LEVELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lsh_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lsh_pkg::t_out_word             o_out_word
);

    lsh_pkg::t_cfg   cfg;
    logic            push_valid, push_ready;
    lsh_pkg::t_qword push_word;
    logic            pop_valid, pop_ready;
    lsh_pkg::t_qword pop_word;

    lsh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_word  (push_word),
        .o_cfg        (cfg)
    );

    lsh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_word  (push_word),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_word   (pop_word)
    );

    lsh_back #(
        .LOD_LEVELS (LOD_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_word  (pop_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hdl/lsh_front.sv =====
// front end: configuration registers, input word classification and corner differences
// depends on lsh_pkg

module lsh_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lsh_pkg::t_in_word                i_in_word,
    output logic                             o_push_valid,
    input  logic                             i_push_ready,
    output lsh_pkg::t_qword                  o_push_word,
    output lsh_pkg::t_cfg                    o_cfg
);

    lsh_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_x            <= '0;
            r_cfg.cam_y            <= '0;
            r_cfg.cam_z            <= '0;
            r_cfg.tan_half_fov     <= 16'd4096;
            r_cfg.forced_level     <= 5'h1F;
            r_cfg.hysteresis       <= '0;
            r_cfg.level_thresholds <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsh_pkg::REG_CAM_X:      r_cfg.cam_x            <= i_cfg_data[23:0];
                lsh_pkg::REG_CAM_Y:      r_cfg.cam_y            <= i_cfg_data[23:0];
                lsh_pkg::REG_CAM_Z:      r_cfg.cam_z            <= i_cfg_data[23:0];
                lsh_pkg::REG_TAN:        r_cfg.tan_half_fov     <= i_cfg_data[15:0];
                lsh_pkg::REG_FORCED:     r_cfg.forced_level     <= i_cfg_data[4:0];
                lsh_pkg::REG_HYST:       r_cfg.hysteresis       <= i_cfg_data[15:0];
                lsh_pkg::REG_THRESHOLDS: r_cfg.level_thresholds <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    function automatic logic [23:0] mag_d(input logic [23:0] mn, input logic [23:0] mx);
        logic [24:0] d;
        d = {mx[23], mx} - {mn[23], mn};
        if (d[24]) begin
            d = -d;
        end
        return d[23:0];
    endfunction

    function automatic logic [25:0] mag_e(input logic [23:0] mn, input logic [23:0] mx,
                                          input logic [23:0] c);
        logic [26:0] e;
        e = {{3{mn[23]}}, mn} + {{3{mx[23]}}, mx} - {{2{c[23]}}, c, 1'b0};
        if (e[26]) begin
            e = -e;
        end
        return e[25:0];
    endfunction

    lsh_pkg::t_meta meta;
    logic [3:0]     cnt_m1;

    always_comb begin
        cnt_m1        = i_in_word.level_count - 4'd1;
        meta.count    = i_in_word.level_count;
        meta.prev     = i_in_word.prev_level;
        if (!r_cfg.forced_level[4]) begin
            meta.use_calc = 1'b0;
            meta.wr_fixed = 1'b1;
            if (i_in_word.level_count == 4'd0) begin
                meta.lvl_fixed = 4'd0;
            end else if (r_cfg.forced_level[3:0] < cnt_m1) begin
                meta.lvl_fixed = r_cfg.forced_level[3:0];
            end else begin
                meta.lvl_fixed = cnt_m1;
            end
        end else begin
            meta.use_calc  = (i_in_word.level_count > 4'd1);
            meta.wr_fixed  = 1'b0;
            meta.lvl_fixed = 4'd0;
        end
    end

    assign o_push_word.meta = meta;
    assign o_push_word.dx   = mag_d(i_in_word.box_min_x, i_in_word.box_max_x);
    assign o_push_word.dy   = mag_d(i_in_word.box_min_y, i_in_word.box_max_y);
    assign o_push_word.dz   = mag_d(i_in_word.box_min_z, i_in_word.box_max_z);
    assign o_push_word.ex   = mag_e(i_in_word.box_min_x, i_in_word.box_max_x, r_cfg.cam_x);
    assign o_push_word.ey   = mag_e(i_in_word.box_min_y, i_in_word.box_max_y, r_cfg.cam_y);
    assign o_push_word.ez   = mag_e(i_in_word.box_min_z, i_in_word.box_max_z, r_cfg.cam_z);

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

// ===== hdl/lsh_queue.sv =====
// short queue between front end and back end
// depends on lsh_pkg

module lsh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  lsh_pkg::t_qword i_push_word,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output lsh_pkg::t_qword o_pop_word
);

    localparam int PTR_W = $clog2(lsh_pkg::QDEPTH);

    lsh_pkg::t_qword     r_mem [0:lsh_pkg::QDEPTH-1];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [PTR_W:0]      r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(lsh_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_word   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/lsh_back.sv =====
// back end: squares, square roots, division and threshold selection, one word per cycle unless the output stalls
// depends on lsh_pkg

module lsh_back #(
    parameter int LOD_LEVELS = lsh_pkg::LOD_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsh_pkg::t_cfg      i_cfg,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  lsh_pkg::t_qword    i_pop_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lsh_pkg::t_out_word o_out_word
);

    localparam int NCMP  = (LOD_LEVELS - 1 < 3) ? LOD_LEVELS - 1 : 3;
    localparam int NSQ   = lsh_pkg::SQ_STEPS;
    localparam int NDIV  = lsh_pkg::FRAC_W;
    localparam int SQ_W  = lsh_pkg::SQ_W;

    typedef logic [NCMP-1:0][15:0] t_thr;

    logic en;
    logic r_o_v;

    assign en          = !r_o_v || i_out_ready;
    assign o_pop_ready = en;

    // squares
    logic            r_a_v;
    lsh_pkg::t_meta  r_a_meta;
    logic [47:0]     r_a_dx2, r_a_dy2, r_a_dz2;
    logic [SQ_W-1:0] r_a_ex2, r_a_ey2, r_a_ez2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_meta <= i_pop_word.meta;
            r_a_dx2  <= i_pop_word.dx * i_pop_word.dx;
            r_a_dy2  <= i_pop_word.dy * i_pop_word.dy;
            r_a_dz2  <= i_pop_word.dz * i_pop_word.dz;
            r_a_ex2  <= i_pop_word.ex * i_pop_word.ex;
            r_a_ey2  <= i_pop_word.ey * i_pop_word.ey;
            r_a_ez2  <= i_pop_word.ez * i_pop_word.ez;
        end
    end

    // sums, then square root pipeline
    logic            r_s_v    [0:NSQ];
    lsh_pkg::t_meta  r_s_meta [0:NSQ];
    lsh_pkg::t_sqrt  r_sg     [0:NSQ];
    lsh_pkg::t_sqrt  r_sh     [0:NSQ];
    logic [SQ_W-1:0] dsum;
    logic [SQ_W-1:0] esum;
    lsh_pkg::t_meta  a_meta_gated;

    assign dsum = SQ_W'(r_a_dx2) + SQ_W'(r_a_dy2) + SQ_W'(r_a_dz2);
    assign esum = r_a_ex2 + r_a_ey2 + r_a_ez2;

    // camera at box center falls back to level zero without write
    always_comb begin
        a_meta_gated          = r_a_meta;
        a_meta_gated.use_calc = r_a_meta.use_calc && (esum != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_meta[0] <= a_meta_gated;
            r_sg[0]     <= '{rad: dsum, rem: '0, root: '0};
            r_sh[0]     <= '{rad: esum, rem: '0, root: '0};
        end
    end

    for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_meta[k] <= r_s_meta[k-1];
                r_sg[k]     <= lsh_pkg::sqrt_step(r_sg[k-1]);
                r_sh[k]     <= lsh_pkg::sqrt_step(r_sh[k-1]);
            end
        end
    end

    // denominator, saturation check and widened thresholds
    logic                         r_d_v    [0:NDIV];
    lsh_pkg::t_meta               r_d_meta [0:NDIV];
    lsh_pkg::t_div                r_d      [0:NDIV];
    logic                         r_d_sat  [0:NDIV];
    t_thr                         r_d_thr  [0:NDIV];
    logic [lsh_pkg::ROOT_W-1:0]   g;
    logic [lsh_pkg::DEN_W-1:0]    den;
    logic                         sat;
    t_thr                         thr_sel;

    assign g   = r_sg[NSQ].root;
    assign den = r_sh[NSQ].root * i_cfg.tan_half_fov;
    assign sat = (den == '0) || ({8'd0, g, 8'd0} >= den);

    always_comb begin
        logic [15:0] raw;
        logic [31:0] prod;
        logic [16:0] sum;
        thr_sel = '0;
        for (int t = 0; t < NCMP; t++) begin
            raw  = i_cfg.level_thresholds[16*t +: 16];
            prod = raw * i_cfg.hysteresis;
            sum  = {1'b0, raw} + {1'b0, prod[31:16]};
            if (r_s_meta[NSQ].prev > 4'(t)) begin
                thr_sel[t] = sum[16] ? 16'hFFFF : sum[15:0];
            end else begin
                thr_sel[t] = raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_meta[0] <= r_s_meta[NSQ];
            r_d[0].rem  <= {8'd0, g, 24'd0};
            r_d[0].dsh  <= {1'b0, den, 15'd0};
            r_d[0].q    <= '0;
            r_d_sat[0]  <= sat;
            r_d_thr[0]  <= thr_sel;
        end
    end

    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_meta[k] <= r_d_meta[k-1];
                r_d[k]      <= lsh_pkg::div_step(r_d[k-1]);
                r_d_sat[k]  <= r_d_sat[k-1];
                r_d_thr[k]  <= r_d_thr[k-1];
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            for (int k = 0; k <= NSQ; k++) begin
                r_s_v[k] <= 1'b0;
            end
            for (int k = 0; k <= NDIV; k++) begin
                r_d_v[k] <= 1'b0;
            end
            r_o_v <= 1'b0;
        end else if (en) begin
            r_a_v    <= i_pop_valid;
            r_s_v[0] <= r_a_v;
            for (int k = 1; k <= NSQ; k++) begin
                r_s_v[k] <= r_s_v[k-1];
            end
            r_d_v[0] <= r_s_v[NSQ];
            for (int k = 1; k <= NDIV; k++) begin
                r_d_v[k] <= r_d_v[k-1];
            end
            r_o_v <= r_d_v[NDIV];
        end
    end

    // level selection
    lsh_pkg::t_out_word       n_out;
    lsh_pkg::t_out_word       r_out;
    logic [15:0]              frac;
    lsh_pkg::t_meta           fm;

    always_comb begin
        fm   = r_d_meta[NDIV];
        frac = r_d_sat[NDIV] ? 16'hFFFF : r_d[NDIV].q;
        if (fm.use_calc) begin
            n_out.level       = 4'd0;
            n_out.cache_write = 1'b1;
            for (int t = 0; t < NCMP; t++) begin
                if ((4'(t) < fm.count - 4'd1) && (frac < r_d_thr[NDIV][t])) begin
                    n_out.level = 4'(t + 1);
                end
            end
        end else begin
            n_out.level       = fm.lvl_fixed;
            n_out.cache_write = fm.wr_fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_word  = r_out;

endmodule

// ===== hdl/lsh_checker.sv =====
// port level checks for lod_select_hysteresis_core, attached by bind
// depends on lsh_pkg and lod_select_hysteresis_core

module lsh_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input lsh_pkg::t_in_word              i_in_word,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input lsh_pkg::t_out_word             o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("waiting input word changed or dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed or dropped");

    a_nowrite_level0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.cache_write |-> o_out_word.level == 4'd0)
        else $error("nonzero level without cache write");

endmodule

bind lod_select_hysteresis_core lsh_checker u_lsh_checker (.*);
